[rtl/tcon_pkg.sv]
package tcon_pkg;

  typedef enum logic [2:0] {
    CMD_PRINT  = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_UP     = 3'd4,
    CMD_DOWN   = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  localparam logic [7:0]  CH_NL = 8'h0a;
  localparam logic [7:0]  CH_CR = 8'h0d;
  localparam logic [7:0]  CH_BS = 8'h08;
  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  TAB_MASK = 8'hf8;
  localparam logic [7:0]  TAB_STEP = 8'd8;
  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [1:0]  ADDR_TEXT_COLOR = 2'd0;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] view_lines;
  } item_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        cursor_visible;
    logic [15:0] cell_value;
    logic [7:0]  view_back;
  } item_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_CLR,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_SC_HRD,
    ST_SC_HWR,
    ST_SH_RD,
    ST_SH_WR,
    ST_BLANK,
    ST_DONE
  } state_t;

endpackage

[rtl/tcon_ram.sv]
module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/text_console_with_scrollback_core.sv]
// text console core: an 80x25 (by default) screen of 16-bit cells (character in
// the low byte, attribute in the high byte), a cursor and a ring of evicted
// rows. pulse start while busy is low to hand in one command item; exactly one
// result item follows, shown for a single cycle with done high, and it must be
// taken in that cycle since there is no way to hold it. after reset the screen
// memory is swept to blank cells, which keeps busy high until the sweep ends.
// a plain character, cursor move, view scroll or cell write runs an execute
// state and then done; a read cell adds a ram issue and a wait state, and tab
// adds a state per blanked cell. a line feed at the bottom row copies the top
// row to the ring and moves the rest up a row with a read and then a write per
// cell, set by the single read port of the screen ram, then blanks the bottom
// row. clear writes the whole screen, one cell write per cell.
module text_console_with_scrollback_core #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int HISTORY_LINES = 200
) (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                start,
  input  tcon_pkg::item_in_t  item,
  output logic                busy,
  output logic                done,
  output tcon_pkg::item_out_t result,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int HCELLS = HISTORY_LINES * SCREEN_COLS;
  localparam int SA_W = $clog2(CELLS);
  localparam int HA_W = $clog2(HCELLS);

  tcon_pkg::state_t   state, state_next;
  tcon_pkg::item_in_t in_q;
  logic [SA_W-1:0]    idx;
  logic [4:0]         cur_row;
  logic [6:0]         cur_col;
  logic [7:0]         hist_next;
  logic [7:0]         hist_count;
  logic [7:0]         view_off;
  logic [7:0]         text_color;
  logic [15:0]        cell_val;
  logic [7:0]         rd_row;
  logic               rd_hist;
  logic [7:0]         tab_stop;

  // memory ports
  logic              scr_we;
  logic [SA_W-1:0]   scr_waddr, scr_raddr;
  logic [15:0]       scr_wdata, scr_rdata;
  logic              his_we;
  logic [HA_W-1:0]   his_waddr, his_raddr;
  logic [15:0]       his_rdata;

  tcon_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  tcon_ram #(.WIDTH(16), .DEPTH(HCELLS)) u_history (
    .clk(clk), .we(his_we), .waddr(his_waddr), .wdata(scr_rdata),
    .raddr(his_raddr), .rdata(his_rdata)
  );

  // register port: a single attribute register at address 0, read back anywhere
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {24'd0, text_color};

  // decode of the latched command
  logic [15:0]     blank;
  logic [SA_W-1:0] cur_addr;
  logic [7:0]      col_p8, stop;
  logic            is_print, is_nl, is_cr, is_bs, is_tab, is_plain;
  logic            tab_wrap, eol, at_bottom, nl_req;
  logic            row_ok, col_ok;
  logic [8:0]      r_plus_hc;
  logic [9:0]      line_sum;
  logic [7:0]      line;
  logic [8:0]      up_sum;

  assign blank     = {text_color, tcon_pkg::CH_SPACE};
  assign cur_addr  = SA_W'(SA_W'(cur_row) * SA_W'(SCREEN_COLS) + SA_W'(cur_col));
  assign is_print  = (in_q.cmd == tcon_pkg::CMD_PRINT);
  assign is_nl     = (in_q.char_code == tcon_pkg::CH_NL);
  assign is_cr     = (in_q.char_code == tcon_pkg::CH_CR);
  assign is_bs     = (in_q.char_code == tcon_pkg::CH_BS);
  assign is_tab    = (in_q.char_code == tcon_pkg::CH_TAB);
  assign is_plain  = !(is_nl || is_cr || is_bs || is_tab);
  assign col_p8    = {1'b0, cur_col} + tcon_pkg::TAB_STEP;
  assign stop      = col_p8 & tcon_pkg::TAB_MASK;
  assign tab_wrap  = (stop >= 8'(SCREEN_COLS));
  assign eol       = (cur_col == 7'(SCREEN_COLS - 1));
  assign at_bottom = (cur_row == 5'(SCREEN_ROWS - 1));
  assign nl_req    = is_print && (is_nl || (is_tab && tab_wrap) || (is_plain && eol));
  assign row_ok    = ({1'b0, in_q.row} < 6'(SCREEN_ROWS));
  assign col_ok    = ({1'b0, in_q.col} < 8'(SCREEN_COLS));
  assign r_plus_hc = 9'(in_q.row) + 9'(hist_count);
  // ring line of a displayed history row: oldest line plus distance from top
  assign line_sum  = 10'(hist_next) + 10'(HISTORY_LINES) + 10'(in_q.row) - 10'(view_off);
  assign line      = (line_sum >= 10'(HISTORY_LINES)) ?
                     8'(line_sum - 10'(HISTORY_LINES)) : 8'(line_sum);
  assign up_sum    = 9'(view_off) + 9'(in_q.view_lines);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcon_pkg::ST_INIT: begin
        if (idx == SA_W'(CELLS - 1)) state_next = tcon_pkg::ST_IDLE;
      end
      tcon_pkg::ST_IDLE: begin
        if (start) state_next = tcon_pkg::ST_EXEC;
      end
      tcon_pkg::ST_EXEC: begin
        state_next = tcon_pkg::ST_DONE;
        case (in_q.cmd)
          tcon_pkg::CMD_PRINT: begin
            if (nl_req) begin
              if (at_bottom) state_next = tcon_pkg::ST_SC_HRD;
            end else if (is_tab) begin
              state_next = tcon_pkg::ST_TAB;
            end
          end
          tcon_pkg::CMD_CLEAR: state_next = tcon_pkg::ST_CLR;
          tcon_pkg::CMD_READ: begin
            if (row_ok && col_ok &&
                !(9'(in_q.row) < 9'(view_off) && r_plus_hc < 9'(view_off))) begin
              state_next = tcon_pkg::ST_RD_ISSUE;
            end
          end
          default: state_next = tcon_pkg::ST_DONE;
        endcase
      end
      tcon_pkg::ST_TAB: begin
        if ({1'b0, cur_col} + 8'd1 == tab_stop) state_next = tcon_pkg::ST_DONE;
      end
      tcon_pkg::ST_CLR: begin
        if (idx == SA_W'(CELLS - 1)) state_next = tcon_pkg::ST_DONE;
      end
      tcon_pkg::ST_RD_ISSUE: state_next = tcon_pkg::ST_RD_WAIT;
      tcon_pkg::ST_RD_WAIT:  state_next = tcon_pkg::ST_DONE;
      tcon_pkg::ST_SC_HRD:   state_next = tcon_pkg::ST_SC_HWR;
      tcon_pkg::ST_SC_HWR: begin
        state_next = (idx == SA_W'(SCREEN_COLS - 1)) ? tcon_pkg::ST_SH_RD :
                                                       tcon_pkg::ST_SC_HRD;
      end
      tcon_pkg::ST_SH_RD: state_next = tcon_pkg::ST_SH_WR;
      tcon_pkg::ST_SH_WR: begin
        state_next = (idx == SA_W'(CELLS - SCREEN_COLS - 1)) ? tcon_pkg::ST_BLANK :
                                                               tcon_pkg::ST_SH_RD;
      end
      tcon_pkg::ST_BLANK: begin
        if (idx == SA_W'(SCREEN_COLS - 1)) state_next = tcon_pkg::ST_DONE;
      end
      tcon_pkg::ST_DONE: state_next = tcon_pkg::ST_IDLE;
      default: state_next = tcon_pkg::ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = idx;
    scr_wdata = blank;
    scr_raddr = idx;
    his_we    = 1'b0;
    his_waddr = HA_W'(HA_W'(hist_next) * HA_W'(SCREEN_COLS) + HA_W'(idx));
    his_raddr = HA_W'(HA_W'(rd_row) * HA_W'(SCREEN_COLS) + HA_W'(in_q.col));
    case (state)
      tcon_pkg::ST_INIT: begin
        scr_we    = 1'b1;
        scr_wdata = tcon_pkg::RESET_CELL;
      end
      tcon_pkg::ST_EXEC: begin
        if (is_print) begin
          if (is_bs && cur_col != 7'd0) begin
            scr_we    = 1'b1;
            scr_waddr = cur_addr - SA_W'(1);
          end else if (is_plain) begin
            scr_we    = 1'b1;
            scr_waddr = cur_addr;
            scr_wdata = {text_color, in_q.char_code};
          end
        end else if (in_q.cmd == tcon_pkg::CMD_WRITE && row_ok && col_ok) begin
          scr_we    = 1'b1;
          scr_waddr = SA_W'(SA_W'(in_q.row) * SA_W'(SCREEN_COLS) + SA_W'(in_q.col));
          scr_wdata = {in_q.cell_color, in_q.char_code};
        end
      end
      tcon_pkg::ST_TAB: begin
        scr_we    = 1'b1;
        scr_waddr = cur_addr;
      end
      tcon_pkg::ST_CLR: scr_we = 1'b1;
      tcon_pkg::ST_RD_ISSUE: begin
        scr_raddr = SA_W'(SA_W'(rd_row) * SA_W'(SCREEN_COLS) + SA_W'(in_q.col));
      end
      tcon_pkg::ST_SC_HWR: his_we = 1'b1;
      tcon_pkg::ST_SH_RD: scr_raddr = idx + SA_W'(SCREEN_COLS);
      tcon_pkg::ST_SH_WR: begin
        scr_we    = 1'b1;
        scr_wdata = scr_rdata;
      end
      tcon_pkg::ST_BLANK: begin
        scr_we    = 1'b1;
        scr_waddr = SA_W'(CELLS - SCREEN_COLS) + idx;
      end
      default: ;
    endcase
  end

  assign busy = (state != tcon_pkg::ST_IDLE);
  assign done = (state == tcon_pkg::ST_DONE);

  assign result.cursor_row     = cur_row;
  assign result.cursor_col     = cur_col;
  assign result.cursor_visible = (view_off == 8'd0);
  assign result.cell_value     = cell_val;
  assign result.view_back      = view_off;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcon_pkg::ST_INIT;
      idx        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      hist_next  <= '0;
      hist_count <= '0;
      view_off   <= '0;
      text_color <= tcon_pkg::RESET_COLOR;
    end else begin
      state <= state_next;
      if (cfg_wr && paddr == tcon_pkg::ADDR_TEXT_COLOR) text_color <= pwdata[7:0];
      case (state)
        tcon_pkg::ST_INIT: idx <= idx + SA_W'(1);
        tcon_pkg::ST_EXEC: begin
          idx <= '0;
          case (in_q.cmd)
            tcon_pkg::CMD_PRINT: begin
              if (nl_req) begin
                cur_col <= '0;
                if (!at_bottom) cur_row <= cur_row + 5'd1;
              end else if (is_cr) begin
                cur_col <= '0;
              end else if (is_bs) begin
                if (cur_col != 7'd0) cur_col <= cur_col - 7'd1;
              end else if (is_plain) begin
                cur_col <= cur_col + 7'd1;
              end
            end
            tcon_pkg::CMD_CURSOR: begin
              if (row_ok) cur_row <= in_q.row;
              if (col_ok) cur_col <= in_q.col;
            end
            tcon_pkg::CMD_CLEAR: begin
              cur_row <= '0;
              cur_col <= '0;
            end
            tcon_pkg::CMD_UP: begin
              if (hist_count != 8'd0) begin
                view_off <= (up_sum > 9'(hist_count)) ? hist_count : up_sum[7:0];
              end
            end
            tcon_pkg::CMD_DOWN: begin
              view_off <= (in_q.view_lines >= view_off) ? 8'd0 :
                          view_off - in_q.view_lines;
            end
            default: ;
          endcase
        end
        tcon_pkg::ST_TAB: cur_col <= cur_col + 7'd1;
        tcon_pkg::ST_CLR: idx <= idx + SA_W'(1);
        tcon_pkg::ST_SC_HWR: begin
          idx <= (idx == SA_W'(SCREEN_COLS - 1)) ? '0 : idx + SA_W'(1);
        end
        tcon_pkg::ST_SH_WR: begin
          idx <= (idx == SA_W'(CELLS - SCREEN_COLS - 1)) ? '0 : idx + SA_W'(1);
        end
        tcon_pkg::ST_BLANK: begin
          idx <= idx + SA_W'(1);
          if (idx == SA_W'(SCREEN_COLS - 1)) begin
            // evicted row is now in the ring
            hist_next <= (hist_next == 8'(HISTORY_LINES - 1)) ? 8'd0 : hist_next + 8'd1;
            if (hist_count < 8'(HISTORY_LINES)) hist_count <= hist_count + 8'd1;
            cur_row <= 5'(SCREEN_ROWS - 1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == tcon_pkg::ST_IDLE && start) in_q <= item;
    if (state == tcon_pkg::ST_EXEC) begin
      cell_val <= 16'd0;
      tab_stop <= stop;
      if (in_q.cmd == tcon_pkg::CMD_READ && row_ok && col_ok) begin
        if (9'(in_q.row) < 9'(view_off)) begin
          // row above the oldest ring line shows blank
          if (r_plus_hc < 9'(view_off)) cell_val <= blank;
          rd_hist <= 1'b1;
          rd_row  <= line;
        end else begin
          rd_hist <= 1'b0;
          rd_row  <= 8'(in_q.row) - view_off;
        end
      end
    end
    if (state == tcon_pkg::ST_RD_WAIT) cell_val <= rd_hist ? his_rdata : scr_rdata;
  end

  // checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_view_bound: assert property (@(posedge clk) disable iff (rst)
    view_off <= hist_count) else $error("view offset beyond ring fill");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cur_row < 5'(SCREEN_ROWS) && cur_col < 7'(SCREEN_COLS)))
    else $error("cursor out of screen at result");

endmodule

[dv/tcon_checker.sv]
module tcon_checker #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int HISTORY_LINES = 200
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  tcon_pkg::item_in_t  item,
  input  logic                done,
  input  tcon_pkg::item_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  fail_count,
  output int                  pending
);

  logic [15:0] scr [SCREEN_ROWS*SCREEN_COLS];
  logic [15:0] hist [HISTORY_LINES*SCREEN_COLS];
  int unsigned crow, ccol, hnext, hcount, voff;
  logic [7:0] color;
  tcon_pkg::item_out_t status_q[$];

  assign pending = status_q.size();

  function automatic logic [15:0] blank();
    return {color, tcon_pkg::CH_SPACE};
  endfunction

  function automatic void put(int unsigned r, int unsigned c, logic [15:0] v);
    if (r < SCREEN_ROWS && c < SCREEN_COLS) scr[r*SCREEN_COLS+c] = v;
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < SCREEN_COLS; i++) hist[hnext*SCREEN_COLS+i] = scr[i];
    hnext = (hnext + 1) % HISTORY_LINES;
    if (hcount < HISTORY_LINES) hcount++;
    for (int i = 0; i < (SCREEN_ROWS-1)*SCREEN_COLS; i++) scr[i] = scr[i+SCREEN_COLS];
    for (int i = 0; i < SCREEN_COLS; i++) scr[(SCREEN_ROWS-1)*SCREEN_COLS+i] = blank();
    crow = SCREEN_ROWS - 1;
  endfunction

  function automatic void line_feed();
    ccol = 0;
    crow++;
    if (crow >= SCREEN_ROWS) scroll_up();
  endfunction

  function automatic void print_char(logic [7:0] ch);
    int unsigned stop;
    if (ch == tcon_pkg::CH_NL) line_feed();
    else if (ch == tcon_pkg::CH_CR) ccol = 0;
    else if (ch == tcon_pkg::CH_BS) begin
      if (ccol > 0) begin
        ccol--;
        put(crow, ccol, blank());
      end
    end else if (ch == tcon_pkg::CH_TAB) begin
      stop = (ccol + 32'(tcon_pkg::TAB_STEP)) & ~32'd7;
      if (stop >= SCREEN_COLS) line_feed();
      else while (ccol < stop) begin
        put(crow, ccol, blank());
        ccol++;
      end
    end else begin
      put(crow, ccol, {color, ch});
      ccol++;
      if (ccol >= SCREEN_COLS) line_feed();
    end
  endfunction

  // cell as the current view shows it
  function automatic logic [15:0] shown_cell(int unsigned r, int unsigned c);
    int unsigned pos, line;
    if (r + hcount < voff) return blank();
    pos = r + hcount - voff;
    if (pos < hcount) begin
      line = (hnext + HISTORY_LINES - hcount + pos) % HISTORY_LINES;
      return hist[line*SCREEN_COLS+c];
    end
    pos -= hcount;
    if (pos >= SCREEN_ROWS) return blank();
    return scr[pos*SCREEN_COLS+c];
  endfunction

  function automatic tcon_pkg::item_out_t run_command(tcon_pkg::item_in_t it);
    tcon_pkg::item_out_t o;
    logic [15:0] val;
    val = '0;
    case (tcon_pkg::cmd_t'(it.cmd))
      tcon_pkg::CMD_PRINT:  print_char(it.char_code);
      tcon_pkg::CMD_WRITE:  put(32'(it.row), 32'(it.col), {it.cell_color, it.char_code});
      tcon_pkg::CMD_CURSOR: begin
        if (it.row < SCREEN_ROWS) crow = 32'(it.row);
        if (it.col < SCREEN_COLS) ccol = 32'(it.col);
      end
      tcon_pkg::CMD_CLEAR: begin
        for (int i = 0; i < SCREEN_ROWS*SCREEN_COLS; i++) scr[i] = blank();
        crow = 0;
        ccol = 0;
      end
      tcon_pkg::CMD_UP: if (hcount != 0) begin
        voff += 32'(it.view_lines);
        if (voff > hcount) voff = hcount;
      end
      tcon_pkg::CMD_DOWN: voff = (32'(it.view_lines) >= voff) ? 0 :
                                 voff - 32'(it.view_lines);
      tcon_pkg::CMD_READ: if (it.row < SCREEN_ROWS && it.col < SCREEN_COLS)
        val = shown_cell(32'(it.row), 32'(it.col));
      default: ;
    endcase
    o.cursor_row = 5'(crow);
    o.cursor_col = 7'(ccol);
    o.cursor_visible = (voff == 0);
    o.cell_value = val;
    o.view_back = 8'(voff);
    return o;
  endfunction

  always @(posedge clk) begin
    tcon_pkg::item_out_t want;
    if (rst) begin
      for (int i = 0; i < SCREEN_ROWS*SCREEN_COLS; i++) scr[i] = tcon_pkg::RESET_CELL;
      for (int i = 0; i < HISTORY_LINES*SCREEN_COLS; i++) hist[i] = '0;
      crow = 0; ccol = 0; hnext = 0; hcount = 0; voff = 0;
      color = tcon_pkg::RESET_COLOR;
      status_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == tcon_pkg::ADDR_TEXT_COLOR)
        color = pwdata[7:0];
      if (done) begin
        if (status_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (result.cursor_row !== want.cursor_row) begin
            $error("cursor_row exp %0d got %0d", want.cursor_row, result.cursor_row);
            fail_count++;
          end
          if (result.cursor_col !== want.cursor_col) begin
            $error("cursor_col exp %0d got %0d", want.cursor_col, result.cursor_col);
            fail_count++;
          end
          if (result.cursor_visible !== want.cursor_visible) begin
            $error("cursor_visible exp %0d got %0d", want.cursor_visible,
                   result.cursor_visible);
            fail_count++;
          end
          if (result.cell_value !== want.cell_value) begin
            $error("cell_value exp %h got %h", want.cell_value, result.cell_value);
            fail_count++;
          end
          if (result.view_back !== want.view_back) begin
            $error("view_back exp %0d got %0d", want.view_back, result.view_back);
            fail_count++;
          end
        end
      end
      if (start && !busy) status_q.push_back(run_command(item));
    end
  end
endmodule

[dv/tb_top.sv]
module tb_top;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  tcon_pkg::item_in_t item = '0;
  logic busy, done, pready;
  tcon_pkg::item_out_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending;
  int idle_pct;

  always #10 clk = ~clk;

  text_console_with_scrollback_core uut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tcon_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  // hand in one command item, with random idle cycles before it
  task automatic send(tcon_pkg::cmd_t c, int unsigned ch, int unsigned clr,
                      int unsigned r, int unsigned cl, int unsigned n);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1;
    item <= '{cmd: c, char_code: 8'(ch), cell_color: 8'(clr), row: 5'(r), col: 7'(cl),
              view_lines: 8'(n)};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    @(posedge clk);
  endtask

  // let every item drain, then a margin for the block to settle
  task automatic drain();
    while (pending != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_color(int unsigned v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= tcon_pkg::ADDR_TEXT_COLOR; pwdata <= {24'h0, 8'(v)};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // mostly printable text and line controls, plus reads to look at the screen
  task automatic random_item();
    int unsigned k;
    logic [7:0] ch;
    k = $urandom_range(99);
    case ($urandom_range(3))
      0: ch = tcon_pkg::CH_NL;
      1: ch = tcon_pkg::CH_TAB;
      2: ch = ($urandom_range(1)) ? tcon_pkg::CH_BS : tcon_pkg::CH_CR;
      default: ch = 8'($urandom);
    endcase
    if (k < 45) send(tcon_pkg::CMD_PRINT, (k < 25) ? $urandom : 32'(ch), 0, 0, 0, 0);
    else if (k < 52) send(tcon_pkg::CMD_WRITE, $urandom, $urandom, $urandom, $urandom, 0);
    else if (k < 58) send(tcon_pkg::CMD_CURSOR, 0, 0, $urandom, $urandom, 0);
    else if (k < 59) send(tcon_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    else if (k < 66) send(tcon_pkg::CMD_UP, 0, 0, 0, 0,
                          $urandom_range(1) ? $urandom_range(8) : $urandom);
    else if (k < 72) send(tcon_pkg::CMD_DOWN, 0, 0, 0, 0,
                          $urandom_range(1) ? $urandom_range(8) : $urandom);
    else if (k < 97) send(tcon_pkg::CMD_READ, 0, 0,
                          $urandom_range(1) ? $urandom_range(24) : $urandom,
                          $urandom_range(1) ? $urandom_range(79) : $urandom, 0);
    else send(tcon_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    idle_pct = 0;
    // directed: specials and extremes
    send(tcon_pkg::CMD_UP, 0, 0, 0, 0, 5);              // view up with empty history
    send(tcon_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send(tcon_pkg::CMD_READ, 0, 0, 24, 79, 0);
    send(tcon_pkg::CMD_READ, 0, 0, 31, 127, 0);         // read out of range
    send(tcon_pkg::CMD_WRITE, 'hff, 'hff, 24, 79, 0);
    send(tcon_pkg::CMD_WRITE, 'h41, 'h1e, 31, 127, 0);  // write out of range
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_BS), 0, 0, 0, 0);  // backspace at column 0
    send(tcon_pkg::CMD_CURSOR, 0, 0, 31, 78, 0);        // row out of range only
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_TAB), 0, 0, 0, 0); // tab past last stop
    send(tcon_pkg::CMD_CURSOR, 0, 0, 24, 127, 0);
    send(tcon_pkg::CMD_CURSOR, 0, 0, 24, 79, 0);
    send(tcon_pkg::CMD_PRINT, 'h5a, 0, 0, 0, 0);        // wrap and scroll
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_NL), 0, 0, 0, 0);
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_TAB), 0, 0, 0, 0);
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_CR), 0, 0, 0, 0);
    send(tcon_pkg::CMD_UP, 0, 0, 0, 0, 'hff);           // view up past oldest
    send(tcon_pkg::CMD_PRINT, 'h00, 0, 0, 0, 0);        // output while scrolled back
    send(tcon_pkg::CMD_READ, 0, 0, 0, 5, 0);            // top row shows the oldest ring line
    send(tcon_pkg::CMD_READ, 0, 0, 2, 79, 0);
    send(tcon_pkg::CMD_DOWN, 0, 0, 0, 0, 'hff);         // view down below live
    send(tcon_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    send(tcon_pkg::CMD_NOP, 'hff, 'hff, 31, 127, 'hff);
    set_color('hff);
    send(tcon_pkg::CMD_PRINT, 32'(tcon_pkg::CH_BS), 0, 0, 0, 0);
    send(tcon_pkg::CMD_READ, 0, 0, 0, 0, 0);
    set_color('h00);
    // random phases with different idle rates and colors
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 77 : (p == 3) ? 11 : 0;
      set_color($urandom);
      for (int i = 0; i < 100; i++) random_item();
    end
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // scrolls walk the whole screen memory; generous bound
  initial begin
    #200000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
